>>> sv/assert_macros.svh
// Assertion macros shared by the RTL files.
// Each use expects clk_i and rst_ni in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication with the consequent checked in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/moesi_pkg.sv
// Package for the MOESI snoop coherence block: sizes, state codes, row type.
// No dependencies.
package moesi_pkg;

  localparam int NumCaches = 4;
  localparam int NumLines  = 16;

  localparam int StW   = 3;
  localparam int FuncW = 1;
  localparam int ReqW  = 2;
  localparam int LineW = 4;
  localparam int CntW  = 2;

  // Address width of the line store.
  localparam int LineAw = (NumLines > 1) ? $clog2(NumLines) : 1;
  // Width of an internal peer count.
  localparam int PeerW  = (NumCaches > 2) ? $clog2(NumCaches) : 1;

  typedef enum logic [StW-1:0] {
    ST_I = 3'd0,
    ST_S = 3'd1,
    ST_E = 3'd2,
    ST_O = 3'd3,
    ST_M = 3'd4
  } moesi_state_e;

  typedef enum logic [FuncW-1:0] {
    FN_READ  = 1'b0,
    FN_WRITE = 1'b1
  } moesi_func_e;

  // One line: a state field per cache.
  typedef logic [NumCaches-1:0][StW-1:0] row_t;

endpackage

>>> sv/moesi_if.sv
// Request and response channel interfaces of the MOESI snoop block.
// Depends on moesi_pkg.
interface moesi_req_if;
  logic                         valid;
  logic                         ready;
  logic [moesi_pkg::FuncW-1:0]  func;
  logic [moesi_pkg::ReqW-1:0]   requester;
  logic [moesi_pkg::LineW-1:0]  line_index;

  modport source (output valid, func, requester, line_index, input ready);
  modport sink   (input valid, func, requester, line_index, output ready);
endinterface

interface moesi_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         local_hit;
  logic [moesi_pkg::StW-1:0]    old_state;
  logic [moesi_pkg::StW-1:0]    new_state;
  logic [moesi_pkg::CntW-1:0]   peer_copies;
  logic [moesi_pkg::CntW-1:0]   peers_invalidated;

  modport source (output valid, local_hit, old_state, new_state, peer_copies,
                  peers_invalidated, input ready);
  modport sink   (input valid, local_hit, old_state, new_state, peer_copies,
                  peers_invalidated, output ready);
endinterface

>>> sv/moesi_snoop_coherence_top.sv
// MOESI snoop coherence controller, top level. Depends on moesi_pkg, moesi_if.sv
// and assert_macros.svh.
// Throughput: one request per cycle while the response register is free or being drained,
// set by the single read and write port of the line store.
// Reset clears the per-line valid bits at once; no clearing pass, requests taken right away.
// The response register holds the last result while the next request is looked up.
`include "assert_macros.svh"

module moesi_snoop_coherence_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  moesi_req_if.sink          req_i,
  moesi_rsp_if.source        rsp_o
);
  import moesi_pkg::*;

  // Line store: one row of per-cache states per line, with a registered read.
  row_t                  mem_q [NumLines];
  logic [NumLines-1:0]   row_vld_q;    // row written since reset; else reads all I

  // Lookup stage: request whose row read is in flight.
  logic                  s1_valid_q;
  logic [FuncW-1:0]      s1_func_q;
  logic [ReqW-1:0]       s1_req_q;
  logic [LineW-1:0]      s1_line_q;
  row_t                  rdata_q;
  logic                  rd_vld_q;
  // Forwarding of a write-back that hit the same row in the read cycle.
  logic                  fwd_q;
  row_t                  fwd_row_q;

  // Response register.
  logic                  out_valid_q;
  logic                  hit_q;
  logic [StW-1:0]        old_q;
  logic [StW-1:0]        new_q;
  logic [CntW-1:0]       peers_q;
  logic [CntW-1:0]       killed_q;

  logic                  in_acc;
  logic                  s1_adv;
  logic                  in_range;
  logic                  wr_en;
  logic [LineAw-1:0]     wr_addr;
  logic [LineAw-1:0]     rd_addr;
  row_t                  row;
  row_t                  new_row;
  logic [StW-1:0]        old_st;
  logic [StW-1:0]        new_st;
  logic [PeerW-1:0]      peers;
  logic [PeerW-1:0]      killed;
  logic [CntW-1:0]       peers_sat;
  logic [CntW-1:0]       killed_sat;

  // Handshake: the lookup stage moves on when the response register is free
  // or being drained; a new request enters behind it in the same cycle.
  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign in_acc      = req_i.valid && req_i.ready;

  assign rd_addr = req_i.line_index[LineAw-1:0];
  assign wr_addr = s1_line_q[LineAw-1:0];

  // Out-of-range requester or line: no update, all-zero response.
  assign in_range = (int'(s1_req_q) < NumCaches) && (int'(s1_line_q) < NumLines);

  // Current row: forwarded write-back, stored row, or all I if never written.
  always_comb begin
    if (fwd_q) begin
      row = fwd_row_q;
    end else if (rd_vld_q) begin
      row = rdata_q;
    end else begin
      row = '0;
    end
  end

  // Snoop and state update for one row.
  always_comb begin
    new_row = row;
    old_st  = row[s1_req_q];
    peers   = '0;
    killed  = '0;
    for (int i = 0; i < NumCaches; i++) begin
      if (i != int'(s1_req_q) && row[i] != ST_I) begin
        peers = peers + PeerW'(1);
      end
    end
    new_st = old_st;
    case (moesi_func_e'(s1_func_q))
      FN_READ: begin
        if (old_st == ST_I) begin
          // Read miss: owners downgrade, exclusive holders become shared.
          for (int i = 0; i < NumCaches; i++) begin
            if (i != int'(s1_req_q)) begin
              if (row[i] == ST_M) begin
                new_row[i] = ST_O;
              end else if (row[i] == ST_E) begin
                new_row[i] = ST_S;
              end
            end
          end
          new_st = (peers != '0) ? ST_S : ST_E;
        end
      end
      FN_WRITE: begin
        if (old_st inside {ST_S, ST_O, ST_I}) begin
          // Write from S, O or I: every valid peer copy is invalidated.
          for (int i = 0; i < NumCaches; i++) begin
            if (i != int'(s1_req_q)) begin
              new_row[i] = ST_I;
            end
          end
          killed = peers;
        end
        new_st = ST_M;
      end
      default: begin
        new_st = old_st;
      end
    endcase
    new_row[s1_req_q] = new_st;
  end

  // Counts saturate at the response field's maximum.
  assign peers_sat  = (int'(peers) > 3) ? CntW'(3) : CntW'(peers);
  assign killed_sat = (int'(killed) > 3) ? CntW'(3) : CntW'(killed);

  assign wr_en = s1_adv && in_range;

  // Line store: read on request accept, write back as the lookup moves on.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= new_row;
    end
    if (in_acc) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (wr_en) begin
      row_vld_q[wr_addr] <= 1'b1;
    end
  end

  // Lookup stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        rd_vld_q   <= row_vld_q[rd_addr];
        fwd_q      <= wr_en && (wr_addr == rd_addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_func_q <= req_i.func;
      s1_req_q  <= req_i.requester;
      s1_line_q <= req_i.line_index;
      fwd_row_q <= new_row;
    end
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      hit_q    <= in_range && (old_st != ST_I);
      old_q    <= in_range ? old_st : StW'(ST_I);
      new_q    <= in_range ? new_st : StW'(ST_I);
      peers_q  <= in_range ? peers_sat : '0;
      killed_q <= in_range ? killed_sat : '0;
    end
  end

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.local_hit         = hit_q;
  assign rsp_o.old_state         = old_q;
  assign rsp_o.new_state         = new_q;
  assign rsp_o.peer_copies       = peers_q;
  assign rsp_o.peers_invalidated = killed_q;

  // A write can never invalidate more peers than held the line.
  `ASSERT_CLK(a_kill_le_peers, !out_valid_q || (killed_q <= peers_q), "invalidated > peer copies")
  // Write from exclusive snoops nothing.
  `ASSERT_CLK(a_excl_no_kill, !(out_valid_q && old_q == ST_E) || (killed_q == '0), "E write killed peers")
  // An accepted request occupies the lookup stage with its line.
  `ASSERT_NEXT(a_s1_load, in_acc, s1_valid_q && (s1_line_q == $past(req_i.line_index)), "lookup not loaded")

endmodule
